// ===== rtl/core/lsi_pkg.sv =====
// shared widths and constants for the line segment intersection pipeline
package lsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int CROSS_BITS = 24;

  localparam int N_COORDS  = 8;
  localparam int IN_W      = ((N_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((2 * CROSS_BITS + 7) / 8) * 8;

  // exact widths of the intermediate terms
  localparam int DW    = COORD_BITS + 1;        // line coefficients a, b and extents
  localparam int PW    = DW + COORD_BITS;       // a*x products
  localparam int CW    = PW + 1;                // right-hand side c
  localparam int DETW  = 2 * DW + 1;            // determinant
  localparam int MW    = DW + CW;               // b*c products
  localparam int XDW   = COORD_BITS + DETW;     // x*d products
  localparam int NW    = MW + 1;                // cramer numerators
  localparam int UW    = DETW + DW;             // parameter denominators
  localparam int TW    = NW + 1;                // parameter numerators
  localparam int DVW   = NW + FRAC_BITS;        // scaled dividend
  localparam int STW   = DETW + CROSS_BITS;     // divider state: remainder and quotient

  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = CROSS_BITS / DIV_STEPS;

  typedef logic [STW-1:0] div_st_t;

endpackage

// ===== rtl/core/line_segment_intersection_top.sv =====
// line segment intersection: deep pipeline with a pipelined restoring divider
//
// usage:
//   slave stream: one beat carries both segments, eight signed 16-bit
//   coordinates packed in tdata (first segment start x in the lowest bits)
//   master stream: one beat per input beat, same order; tuser is the hit
//   flag, tdata holds cross_x then cross_y, each signed with 8 fraction bits
//   and truncated toward zero; both are zero when the segments miss
// throughput: one beat per cycle, sustained while m_axis_tready stays high
// stages: from the input beat to the result beat the pipe runs through
//   6 arithmetic stages for line equations, cramer terms and range tests,
//   12 divider stages retiring two quotient bits each, one output register
// stall: every stage has its own valid bit and only moves when the stage
//   ahead is empty or moving, so bubbles close up and s_axis_tready stays
//   high while any stage is free; nothing is dropped or repeated
// reset: clears all valid bits, the pipe comes up empty and ready
// parallel lines count as a miss; a parameter test with a zero extent fails
module line_segment_intersection_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [lsi_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // cross_x, cross_y
  output logic [lsi_pkg::OUT_W-1:0]  m_axis_tdata,
  // hit
  output logic                       m_axis_tuser
);

  localparam int CB   = lsi_pkg::COORD_BITS;
  localparam int XB   = lsi_pkg::CROSS_BITS;
  localparam int DW   = lsi_pkg::DW;
  localparam int PW   = lsi_pkg::PW;
  localparam int CW   = lsi_pkg::CW;
  localparam int DETW = lsi_pkg::DETW;
  localparam int MW   = lsi_pkg::MW;
  localparam int XDW  = lsi_pkg::XDW;
  localparam int NW   = lsi_pkg::NW;
  localparam int UW   = lsi_pkg::UW;
  localparam int TW   = lsi_pkg::TW;
  localparam int DVW  = lsi_pkg::DVW;
  localparam int NDS  = lsi_pkg::DIV_STAGES;
  localparam int NST  = 7 + NDS;   // six arithmetic stages, divider, output
  localparam int DIV0 = 6;         // index of the first divider stage
  localparam int OST  = NST - 1;   // output register

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic lsi_pkg::div_st_t div_step(lsi_pkg::div_st_t st,
                                                logic [DETW-1:0] dv);
    logic [DETW:0] tr;
    lsi_pkg::div_st_t nx;
    tr = {st[lsi_pkg::STW-1:XB], st[XB-1]};
    if (tr >= {1'b0, dv}) begin
      nx = {DETW'(tr - {1'b0, dv}), st[XB-2:0], 1'b1};
    end else begin
      nx = {tr[DETW-1:0], st[XB-2:0], 1'b0};
    end
    return nx;
  endfunction

  // true when t/u lies in [0,1], false for a zero denominator
  function automatic logic in_unit(logic signed [TW-1:0] t, logic signed [UW-1:0] u);
    logic r;
    if (u == '0) begin
      r = 1'b0;
    end else if (!u[UW-1]) begin
      r = (t >= 0) && (t <= u);
    end else begin
      r = (t <= 0) && (t >= u);
    end
    return r;
  endfunction

  // handshake chain: a stage may load when it is empty or its content moves on
  logic [NST-1:0] valid_q;
  logic [NST-1:0] valid_in;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign valid_in      = {valid_q[NST-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // input unpack
  logic signed [CB-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
  assign x0 = s_axis_tdata[0*CB +: CB];
  assign y0 = s_axis_tdata[1*CB +: CB];
  assign x1 = s_axis_tdata[2*CB +: CB];
  assign y1 = s_axis_tdata[3*CB +: CB];
  assign x2 = s_axis_tdata[4*CB +: CB];
  assign y2 = s_axis_tdata[5*CB +: CB];
  assign x3 = s_axis_tdata[6*CB +: CB];
  assign y3 = s_axis_tdata[7*CB +: CB];

  // stage 0: line coefficients and segment extents
  logic signed [CB-1:0] s0_x0_q, s0_y0_q, s0_x2_q, s0_y2_q;
  logic signed [DW-1:0] s0_a1_q, s0_b1_q, s0_a2_q, s0_b2_q, s0_dx1_q, s0_dx2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_x0_q  <= x0;
      s0_y0_q  <= y0;
      s0_x2_q  <= x2;
      s0_y2_q  <= y2;
      s0_a1_q  <= DW'(y1) - DW'(y0);
      s0_b1_q  <= DW'(x0) - DW'(x1);
      s0_a2_q  <= DW'(y3) - DW'(y2);
      s0_b2_q  <= DW'(x2) - DW'(x3);
      s0_dx1_q <= DW'(x1) - DW'(x0);
      s0_dx2_q <= DW'(x3) - DW'(x2);
    end
  end

  // stage 1: first products
  logic signed [CB-1:0] s1_x0_q, s1_y0_q, s1_x2_q, s1_y2_q;
  logic signed [DW-1:0] s1_a1_q, s1_b1_q, s1_a2_q, s1_b2_q, s1_dx1_q, s1_dx2_q;
  logic signed [PW-1:0] s1_ax1_q, s1_by1_q, s1_ax2_q, s1_by2_q;
  logic signed [2*DW-1:0] s1_ab_q, s1_ba_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_x0_q  <= s0_x0_q;
      s1_y0_q  <= s0_y0_q;
      s1_x2_q  <= s0_x2_q;
      s1_y2_q  <= s0_y2_q;
      s1_a1_q  <= s0_a1_q;
      s1_b1_q  <= s0_b1_q;
      s1_a2_q  <= s0_a2_q;
      s1_b2_q  <= s0_b2_q;
      s1_dx1_q <= s0_dx1_q;
      s1_dx2_q <= s0_dx2_q;
      s1_ax1_q <= s0_a1_q * s0_x0_q;
      s1_by1_q <= s0_b1_q * s0_y0_q;
      s1_ax2_q <= s0_a2_q * s0_x2_q;
      s1_by2_q <= s0_b2_q * s0_y2_q;
      s1_ab_q  <= s0_a1_q * s0_b2_q;
      s1_ba_q  <= s0_a2_q * s0_b1_q;
    end
  end

  // stage 2: right-hand sides and determinant
  logic signed [CB-1:0]   s2_x0_q, s2_y0_q, s2_x2_q, s2_y2_q;
  logic signed [DW-1:0]   s2_a1_q, s2_b1_q, s2_a2_q, s2_b2_q, s2_dx1_q, s2_dx2_q;
  logic signed [CW-1:0]   s2_c1_q, s2_c2_q;
  logic signed [DETW-1:0] s2_d_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_x0_q  <= s1_x0_q;
      s2_y0_q  <= s1_y0_q;
      s2_x2_q  <= s1_x2_q;
      s2_y2_q  <= s1_y2_q;
      s2_a1_q  <= s1_a1_q;
      s2_b1_q  <= s1_b1_q;
      s2_a2_q  <= s1_a2_q;
      s2_b2_q  <= s1_b2_q;
      s2_dx1_q <= s1_dx1_q;
      s2_dx2_q <= s1_dx2_q;
      s2_c1_q  <= CW'(s1_ax1_q) + CW'(s1_by1_q);
      s2_c2_q  <= CW'(s1_ax2_q) + CW'(s1_by2_q);
      s2_d_q   <= DETW'(s1_ab_q) - DETW'(s1_ba_q);
    end
  end

  // stage 3: cramer and parameter products
  logic signed [MW-1:0]   s3_b2c1_q, s3_b1c2_q, s3_a1c2_q, s3_a2c1_q;
  logic signed [XDW-1:0]  s3_x0d_q, s3_y0d_q, s3_x2d_q, s3_y2d_q;
  logic signed [UW-1:0]   s3_u1x_q, s3_u1y_q, s3_u2x_q, s3_u2y_q;
  logic signed [DETW-1:0] s3_d_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_b2c1_q <= s2_b2_q * s2_c1_q;
      s3_b1c2_q <= s2_b1_q * s2_c2_q;
      s3_a1c2_q <= s2_a1_q * s2_c2_q;
      s3_a2c1_q <= s2_a2_q * s2_c1_q;
      s3_x0d_q  <= s2_x0_q * s2_d_q;
      s3_y0d_q  <= s2_y0_q * s2_d_q;
      s3_x2d_q  <= s2_x2_q * s2_d_q;
      s3_y2d_q  <= s2_y2_q * s2_d_q;
      s3_u1x_q  <= s2_d_q * s2_dx1_q;
      s3_u1y_q  <= s2_d_q * s2_a1_q;
      s3_u2x_q  <= s2_d_q * s2_dx2_q;
      s3_u2y_q  <= s2_d_q * s2_a2_q;
      s3_d_q    <= s2_d_q;
    end
  end

  // stage 4: numerators
  logic signed [NW-1:0]   s4_nx_q, s4_ny_q;
  logic signed [TW-1:0]   s4_t1x_q, s4_t1y_q, s4_t2x_q, s4_t2y_q;
  logic signed [UW-1:0]   s4_u1x_q, s4_u1y_q, s4_u2x_q, s4_u2y_q;
  logic signed [DETW-1:0] s4_d_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_nx_q  <= NW'(s3_b2c1_q) - NW'(s3_b1c2_q);
      s4_ny_q  <= NW'(s3_a1c2_q) - NW'(s3_a2c1_q);
      s4_t1x_q <= TW'(s3_b2c1_q) - TW'(s3_b1c2_q) - TW'(s3_x0d_q);
      s4_t1y_q <= TW'(s3_a1c2_q) - TW'(s3_a2c1_q) - TW'(s3_y0d_q);
      s4_t2x_q <= TW'(s3_b2c1_q) - TW'(s3_b1c2_q) - TW'(s3_x2d_q);
      s4_t2y_q <= TW'(s3_a1c2_q) - TW'(s3_a2c1_q) - TW'(s3_y2d_q);
      s4_u1x_q <= s3_u1x_q;
      s4_u1y_q <= s3_u1y_q;
      s4_u2x_q <= s3_u2x_q;
      s4_u2y_q <= s3_u2y_q;
      s4_d_q   <= s3_d_q;
    end
  end

  // stage 5: range tests, signs and magnitudes for the divider
  logic            s5_hit_q, s5_negx_q, s5_negy_q;
  logic [NW-1:0]   s5_mnx_q, s5_mny_q;
  logic [DETW-1:0] s5_md_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_hit_q  <= (s4_d_q != '0) &&
                   (in_unit(s4_t1x_q, s4_u1x_q) || in_unit(s4_t1y_q, s4_u1y_q)) &&
                   (in_unit(s4_t2x_q, s4_u2x_q) || in_unit(s4_t2y_q, s4_u2y_q));
      s5_negx_q <= s4_nx_q[NW-1] ^ s4_d_q[DETW-1];
      s5_negy_q <= s4_ny_q[NW-1] ^ s4_d_q[DETW-1];
      s5_mnx_q  <= s4_nx_q[NW-1] ? NW'(-s4_nx_q) : NW'(s4_nx_q);
      s5_mny_q  <= s4_ny_q[NW-1] ? NW'(-s4_ny_q) : NW'(s4_ny_q);
      s5_md_q   <= s4_d_q[DETW-1] ? DETW'(-s4_d_q) : DETW'(s4_d_q);
    end
  end

  // divider stages: two quotient bits each, x and y side by side
  logic [DVW-1:0] dvx, dvy;
  assign dvx = {s5_mnx_q, {lsi_pkg::FRAC_BITS{1'b0}}};
  assign dvy = {s5_mny_q, {lsi_pkg::FRAC_BITS{1'b0}}};

  lsi_pkg::div_st_t dsx_q [NDS];
  lsi_pkg::div_st_t dsy_q [NDS];
  logic [DETW-1:0]  dmd_q [NDS];
  logic [NDS-1:0]   dhit_q, dnegx_q, dnegy_q;

  for (genvar j = 0; j < NDS; j++) begin : g_div
    lsi_pkg::div_st_t inx, iny, ox, oy;
    logic [DETW-1:0]  md;
    logic             hin, ngx, ngy;

    if (j == 0) begin : g_first
      assign inx = {dvx[XB +: DETW], dvx[XB-1:0]};
      assign iny = {dvy[XB +: DETW], dvy[XB-1:0]};
      assign md  = s5_md_q;
      assign hin = s5_hit_q;
      assign ngx = s5_negx_q;
      assign ngy = s5_negy_q;
    end else begin : g_next
      assign inx = dsx_q[j-1];
      assign iny = dsy_q[j-1];
      assign md  = dmd_q[j-1];
      assign hin = dhit_q[j-1];
      assign ngx = dnegx_q[j-1];
      assign ngy = dnegy_q[j-1];
    end

    always_comb begin
      ox = inx;
      oy = iny;
      for (int s = 0; s < lsi_pkg::DIV_STEPS; s++) begin
        ox = div_step(ox, md);
        oy = div_step(oy, md);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DIV0+j]) begin
        dsx_q[j]   <= ox;
        dsy_q[j]   <= oy;
        dmd_q[j]   <= md;
        dhit_q[j]  <= hin;
        dnegx_q[j] <= ngx;
        dnegy_q[j] <= ngy;
      end
    end
  end

  // output register: apply sign, zero on a miss
  logic [XB-1:0] qx, qy;
  logic [XB-1:0] out_x_q, out_y_q;
  logic          out_hit_q;

  assign qx = dsx_q[NDS-1][XB-1:0];
  assign qy = dsy_q[NDS-1][XB-1:0];

  always_ff @(posedge clk_i) begin
    if (en[OST]) begin
      out_hit_q <= dhit_q[NDS-1];
      out_x_q   <= !dhit_q[NDS-1] ? '0 : (dnegx_q[NDS-1] ? XB'(-qx) : qx);
      out_y_q   <= !dhit_q[NDS-1] ? '0 : (dnegy_q[NDS-1] ? XB'(-qy) : qy);
    end
  end

  assign m_axis_tvalid = valid_q[OST];
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = lsi_pkg::OUT_W'({out_y_q, out_x_q});

endmodule

// ===== rtl/core/lsi_checker.sv =====
// port-level checks for the line segment intersection block, bound to the top
module lsi_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lsi_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser
);

  // a stalled result beat stays up
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped under stall");

  // a stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed under stall");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero point");

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // an empty pipe takes beats
  a_reset_ready: assert property (@(posedge clk_i)
    !rst_ni |-> s_axis_tready)
    else $error("input not ready during reset");

endmodule

bind line_segment_intersection_top lsi_checker u_lsi_checker (.*);

// ===== sim/tb_line_segment_intersection_top.sv =====
// testbench for the line segment intersection pipeline: directed and random segment pairs
module tb_line_segment_intersection_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 19;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                           hit;
    logic [lsi_pkg::CROSS_BITS-1:0] cx;
    logic [lsi_pkg::CROSS_BITS-1:0] cy;
  } crossing_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [lsi_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [lsi_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tuser;

  crossing_t crossings_due[$];
  int        failures = 0;
  longint    cycles = 0;
  bit        quiet = 1'b0;

  line_segment_intersection_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // true when t/u lies in [0,1]; a zero divisor never passes
  function automatic bit in_unit(longint t, longint u);
    if (u == 0) return 1'b0;
    if (u > 0) return t >= 0 && t <= u;
    return t <= 0 && t >= u;
  endfunction

  // trunc(n * 2^FRAC_BITS / d) toward zero
  function automatic logic [lsi_pkg::CROSS_BITS-1:0] scaled_quotient(longint n, longint d);
    longint unsigned mn, md, q, r, res;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = mn / md;
    r = mn % md;
    res = (q << lsi_pkg::FRAC_BITS) + ((r << lsi_pkg::FRAC_BITS) / md);
    if ((n < 0) != (d < 0)) res = -res;
    return res[lsi_pkg::CROSS_BITS-1:0];
  endfunction

  function automatic crossing_t predict_crossing(logic [lsi_pkg::IN_W-1:0] beat);
    longint p[8];
    longint a1, b1, c1, a2, b2, c2, d, nx, ny;
    bit on_first, on_second;
    crossing_t res;
    for (int i = 0; i < 8; i++)
      p[i] = longint'($signed(beat[i*lsi_pkg::COORD_BITS +: lsi_pkg::COORD_BITS]));
    a1 = p[3] - p[1]; b1 = p[0] - p[2]; c1 = a1 * p[0] + b1 * p[1];
    a2 = p[7] - p[5]; b2 = p[4] - p[6]; c2 = a2 * p[4] + b2 * p[5];
    d = a1 * b2 - a2 * b1;
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    res = '0;
    if (d != 0) begin
      on_first = in_unit(nx - p[0] * d, d * (p[2] - p[0])) ||
                 in_unit(ny - p[1] * d, d * (p[3] - p[1]));
      on_second = in_unit(nx - p[4] * d, d * (p[6] - p[4])) ||
                  in_unit(ny - p[5] * d, d * (p[7] - p[5]));
      if (on_first && on_second) begin
        res.hit = 1'b1;
        res.cx = scaled_quotient(nx, d);
        res.cy = scaled_quotient(ny, d);
      end
    end
    return res;
  endfunction

  // drive one beat, idling on the way in bursts unless quiet
  task automatic send_segments(logic [15:0] c[8]);
    logic [lsi_pkg::IN_W-1:0] beat;
    int gap;
    for (int i = 0; i < 8; i++)
      beat[i*lsi_pkg::COORD_BITS +: lsi_pkg::COORD_BITS] = c[i];
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    crossings_due.push_back(predict_crossing(beat));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver backpressure in bursts
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(3) == 0) begin
        gap = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (crossings_due.size() == 0) begin
        $error("result beat with no expectation waiting");
        failures++;
      end else begin
        exp_c = crossings_due.pop_front();
        if (m_axis_tuser !== exp_c.hit) begin
          $error("hit expected %0d actual %0d", exp_c.hit, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata[0 +: lsi_pkg::CROSS_BITS] !== exp_c.cx) begin
          $error("cross_x expected %h actual %h", exp_c.cx,
                 m_axis_tdata[0 +: lsi_pkg::CROSS_BITS]);
          failures++;
        end
        if (m_axis_tdata[lsi_pkg::CROSS_BITS +: lsi_pkg::CROSS_BITS] !== exp_c.cy) begin
          $error("cross_y expected %h actual %h", exp_c.cy,
                 m_axis_tdata[lsi_pkg::CROSS_BITS +: lsi_pkg::CROSS_BITS]);
          failures++;
        end
      end
    end
  end

  task automatic send_list(int n, logic [15:0] v[]);
    logic [15:0] c[8];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 8; i++) c[i] = v[k*8 + i];
      send_segments(c);
    end
  endtask

  // crossings, parallels, collinear, zero-length, endpoint touch and extremes
  task automatic test_directed();
    logic [15:0] v[] = '{
      0, 0, 10, 10, 0, 10, 10, 0,                     // plain crossing
      0, 0, 10, 10, 20, 0, 30, 10,                    // parallel lines apart
      0, 0, 10, 0, 0, 5, 10, 5,                       // parallel
      0, 0, 10, 0, 2, 0, 8, 0,                        // collinear overlap
      5, 5, 5, 5, 0, 0, 10, 10,                       // zero-length first
      0, 0, 0, 10, -5, 3, 5, 3,                       // vertical versus horizontal
      0, 0, 10, 0, 10, 0, 10, 10,                     // touch at an end point
      0, 0, 3, 1, 0, 1, 3, 0,                         // fractional point
      -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
      32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
      -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
      -32768, 0, 32767, 1, 0, -32768, 1, 32767,
      16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 0, 0, 16'hFFFF,
      -7, 3, 4, -9, -6, -8, 5, 2                      // negative fraction
    };
    send_list(14, v);
  endtask

  // random pairs: mostly small boxes where hits are common, some full range
  task automatic test_random(int n);
    logic [15:0] c[8];
    int span;
    int base_x, base_y;
    for (int k = 0; k < n; k++) begin
      if (k == n - 150) quiet = 1'b1;
      case ($urandom_range(3))
        0: for (int i = 0; i < 8; i++) c[i] = 16'($urandom);
        1: begin
          span = $urandom_range(1, 40);
          for (int i = 0; i < 8; i++) c[i] = 16'($urandom_range(0, 2 * span)) - 16'(span);
        end
        default: begin
          span = $urandom_range(1, 4000);
          base_x = $urandom_range(0, 50000) - 25000;
          base_y = $urandom_range(0, 50000) - 25000;
          for (int i = 0; i < 8; i++)
            c[i] = 16'(((i % 2) ? base_y : base_x) + $urandom_range(0, span));
        end
      endcase
      send_segments(c);
    end
    drop_valid();
  endtask

  initial begin
    int wait_cycles;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(850);
    wait_cycles = 0;
    while (crossings_due.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
    if (failures == 0 && crossings_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
